/* rtl/core/trpd_pkg.sv */
// Shared types and constants for the TGA run-length pixel decoder.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package trpd_pkg;

   // Packet header values at or above this start a run packet.
   localparam logic [7:0] MAX_RUN = 8'd128;

   // Configuration register indexes.
   localparam logic [1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [1:0] CSR_PIXEL_TOTAL     = 2'd1;
   localparam logic [1:0] CSR_RLE_MODE        = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [2:0]  BPP_RESET   = 3'd3;
   localparam logic [31:0] TOTAL_RESET = 32'd1;
   localparam logic        RLE_RESET   = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_byte;   // an input byte transfers this cycle
      logic load_result; // the output register takes the next result
   } trpd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pixel_done;  // the byte on the input completes a pixel
      logic emit_last;   // the next result is the last one for the pixel
   } trpd_status_type;

endpackage

/* rtl/core/tga_rle_pixel_decoder.sv */
// Top level of the TGA run-length pixel decoder.
// Joins trpd_ctrl and trpd_datapath; depends on trpd_pkg.
`timescale 1ns / 1ps
//
// Usage:
// The req channel carries the image-data byte stream, one byte per transfer.
// The rsp channel returns decoded pixels up to two per transfer, with a pair
// count of one or two, a flag on the last result caused by a byte, and a flag
// on the result that finishes the image. The csr port writes bytes_per_pixel
// (index 0), pixel_total (index 1) and rle_mode (index 2); the user must
// write them only while idle, as the block itself does not enforce it.
// A packet header byte or a byte that does not finish a pixel is taken and
// gives no result. A byte that finishes a pixel gives ceil(count / 2) results
// for a run of count copies; the next byte is taken once the last of those
// results has entered the output register.
// The output register stays full while rsp_ready is low; result loading
// then pauses and the input waits, nothing is lost or repeated.
// Reset sets 3 bytes per pixel, a total of one pixel and RLE mode, and the
// decoder then waits for a packet header.
//

module tga_rle_pixel_decoder
   import trpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_pixel_first,
   output logic [31:0] rsp_pixel_second,
   output logic [1:0]  rsp_pair_count,
   output logic        rsp_run_last,
   output logic        rsp_image_done
);

   trpd_cmd_type    cmd;
   trpd_status_type status;

   // Sequencing and handshakes.
   trpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Decoding state and result register.
   trpd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_stream_byte  (req_stream_byte),
      .cmd              (cmd),
      .status           (status),
      .rsp_pixel_first  (rsp_pixel_first),
      .rsp_pixel_second (rsp_pixel_second),
      .rsp_pair_count   (rsp_pair_count),
      .rsp_run_last     (rsp_run_last),
      .rsp_image_done   (rsp_image_done)
   );

endmodule

/* rtl/core/trpd_ctrl.sv */
// Controller of the TGA run-length pixel decoder: handshakes and sequencing.
// Depends on trpd_pkg for the command and status types.
`timescale 1ns / 1ps

module trpd_ctrl
   import trpd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  trpd_status_type status,
   output trpd_cmd_type    cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The output register can take a result when empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   assign cmd.take_byte   = req_valid && (state_ff == ST_IDLE);
   assign cmd.load_result = (state_ff == ST_EMIT) && out_free;

   // Next state and output valid.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.pixel_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/core/trpd_datapath.sv */
// Datapath of the TGA run-length pixel decoder: configuration, packet state,
// pixel assembly, pixel counting and the result register. Depends on trpd_pkg.
`timescale 1ns / 1ps

module trpd_datapath
   import trpd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic [1:0]      csr_index,
   input  logic [31:0]     csr_wdata,
   input  logic [7:0]      req_stream_byte,
   input  trpd_cmd_type    cmd,
   output trpd_status_type status,
   output logic [31:0]     rsp_pixel_first,
   output logic [31:0]     rsp_pixel_second,
   output logic [1:0]      rsp_pair_count,
   output logic            rsp_run_last,
   output logic            rsp_image_done
);

   // Configuration registers.
   logic [2:0]  bpp_ff;
   logic [31:0] total_ff;
   logic        rle_ff;

   // Packet and image state.
   logic        expect_hdr_ff, expect_hdr_in;
   logic        run_pkt_ff, run_pkt_in;
   logic [7:0]  pkt_left_ff, pkt_left_in;
   logic [1:0]  byte_idx_ff, byte_idx_in;
   logic [31:0] asm_ff, asm_in;
   logic [31:0] decoded_ff, decoded_in;

   // Result sequencing for the current pixel.
   logic [31:0] pix_hold_ff, pix_hold_in;
   logic [7:0]  emit_left_ff, emit_left_in;
   logic        done_hold_ff, done_hold_in;

   // Output register.
   logic [31:0] out_first_ff, out_second_ff;
   logic [1:0]  out_count_ff;
   logic        out_last_ff, out_done_ff;

   logic [2:0]  pix_size;
   logic        is_hdr;
   logic [31:0] new_asm;
   logic [2:0]  idx_plus;
   logic        pixel_done;
   logic [31:0] total_eff;
   logic [32:0] diff;
   logic        below_total;
   logic [31:0] remaining;
   logic        rem_small;
   logic [7:0]  count_raw;
   logic [7:0]  count;
   logic        img_done;
   logic [7:0]  left_dec;
   logic        two_px;
   logic        last_res;

   // Pixel size clamped to one through four bytes.
   always_comb begin
      if (bpp_ff == 3'd0) begin
         pix_size = 3'd1;
      end else if (bpp_ff > 3'd4) begin
         pix_size = 3'd4;
      end else begin
         pix_size = bpp_ff;
      end
   end

   assign is_hdr = rle_ff && expect_hdr_ff;

   // Place the incoming byte in the pixel being assembled.
   always_comb begin
      case (byte_idx_ff)
         2'd0:    new_asm = {24'd0, req_stream_byte};
         2'd1:    new_asm = asm_ff | {16'd0, req_stream_byte, 8'd0};
         2'd2:    new_asm = asm_ff | {8'd0, req_stream_byte, 16'd0};
         2'd3:    new_asm = asm_ff | {req_stream_byte, 24'd0};
         default: new_asm = asm_ff;
      endcase
   end

   assign idx_plus   = {1'b0, byte_idx_ff} + 3'd1;
   assign pixel_done = !is_hdr && (idx_plus >= pix_size);

   // Pixels left in the image; at least one once progress passes the total.
   assign total_eff   = (total_ff == 32'd0) ? 32'd1 : total_ff;
   assign diff        = {1'b0, total_eff} - {1'b0, decoded_ff};
   assign below_total = !diff[32] && (diff[31:0] != 32'd0);
   assign remaining   = below_total ? diff[31:0] : 32'd1;
   assign rem_small   = (remaining[31:8] == 24'd0);

   // Copies of this pixel, limited by what the image still needs.
   always_comb begin
      count_raw = (rle_ff && run_pkt_ff) ? pkt_left_ff : 8'd1;
      if (count_raw == 8'd0) begin
         count_raw = 8'd1;
      end
      if (rem_small && (remaining[7:0] < count_raw)) begin
         count = remaining[7:0];
      end else begin
         count = count_raw;
      end
   end

   assign img_done = rem_small && (count == remaining[7:0]);
   assign left_dec = (pkt_left_ff != 8'd0) ? pkt_left_ff - 8'd1 : pkt_left_ff;

   // Next packet, assembly and counting state on a byte transfer; result countdown on a load.
   always_comb begin
      expect_hdr_in = expect_hdr_ff;
      run_pkt_in    = run_pkt_ff;
      pkt_left_in   = pkt_left_ff;
      byte_idx_in   = byte_idx_ff;
      asm_in        = asm_ff;
      decoded_in    = decoded_ff;
      pix_hold_in   = pix_hold_ff;
      emit_left_in  = emit_left_ff;
      done_hold_in  = done_hold_ff;
      if (cmd.take_byte) begin
         if (is_hdr) begin
            run_pkt_in    = req_stream_byte[7];
            pkt_left_in   = (req_stream_byte >= MAX_RUN)
                          ? req_stream_byte - (MAX_RUN - 8'd1)
                          : req_stream_byte + 8'd1;
            expect_hdr_in = 1'b0;
            byte_idx_in   = 2'd0;
         end else begin
            asm_in = new_asm;
            if (!pixel_done) begin
               byte_idx_in = idx_plus[1:0];
            end else begin
               byte_idx_in  = 2'd0;
               pix_hold_in  = new_asm;
               emit_left_in = count;
               done_hold_in = img_done;
               if (img_done) begin
                  expect_hdr_in = 1'b1;
                  run_pkt_in    = 1'b0;
                  pkt_left_in   = 8'd0;
                  decoded_in    = 32'd0;
               end else begin
                  decoded_in = decoded_ff + {24'd0, count};
                  if (rle_ff) begin
                     if (run_pkt_ff) begin
                        pkt_left_in   = 8'd0;
                        expect_hdr_in = 1'b1;
                     end else begin
                        pkt_left_in = left_dec;
                        if (left_dec == 8'd0) begin
                           expect_hdr_in = 1'b1;
                        end
                     end
                  end
               end
            end
         end
      end else if (cmd.load_result) begin
         emit_left_in = emit_left_ff - (two_px ? 8'd2 : 8'd1);
      end
   end

   // Shape of the next result.
   assign two_px   = (emit_left_ff >= 8'd2);
   assign last_res = (emit_left_ff <= 8'd2);

   assign status.pixel_done = pixel_done;
   assign status.emit_last  = last_res;

   // Configuration and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff        <= BPP_RESET;
         total_ff      <= TOTAL_RESET;
         rle_ff        <= RLE_RESET;
         expect_hdr_ff <= 1'b1;
         run_pkt_ff    <= 1'b0;
         pkt_left_ff   <= 8'd0;
         byte_idx_ff   <= 2'd0;
         asm_ff        <= 32'd0;
         decoded_ff    <= 32'd0;
         emit_left_ff  <= 8'd0;
         done_hold_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_BYTES_PER_PIXEL: bpp_ff   <= csr_wdata[2:0];
               CSR_PIXEL_TOTAL:     total_ff <= csr_wdata;
               CSR_RLE_MODE:        rle_ff   <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         expect_hdr_ff <= expect_hdr_in;
         run_pkt_ff    <= run_pkt_in;
         pkt_left_ff   <= pkt_left_in;
         byte_idx_ff   <= byte_idx_in;
         asm_ff        <= asm_in;
         decoded_ff    <= decoded_in;
         emit_left_ff  <= emit_left_in;
         done_hold_ff  <= done_hold_in;
      end
   end

   // Held pixel and output payload need no reset.
   always_ff @(posedge clock) begin
      pix_hold_ff <= pix_hold_in;
      if (cmd.load_result) begin
         out_first_ff  <= pix_hold_ff;
         out_second_ff <= two_px ? pix_hold_ff : 32'd0;
         out_count_ff  <= two_px ? 2'd2 : 2'd1;
         out_last_ff   <= last_res;
         out_done_ff   <= done_hold_ff && last_res;
      end
   end

   assign rsp_pixel_first  = out_first_ff;
   assign rsp_pixel_second = out_second_ff;
   assign rsp_pair_count   = out_count_ff;
   assign rsp_run_last     = out_last_ff;
   assign rsp_image_done   = out_done_ff;

endmodule
